>>> design/ebp_pkg.sv
// shared types, codes and helpers for the exp-golomb bit packer
`default_nettype none
package ebp_pkg;

	// operation codes on the op field
	localparam logic [1:0] OP_SIGN  = 2'd0;
	localparam logic [1:0] OP_FIELD = 2'd1;
	localparam logic [1:0] OP_EXPG  = 2'd2;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned VALUE_W  = 9;
	localparam int unsigned FW_W     = 4;
	localparam int unsigned CODE_W   = 15;  // longest code: exp-golomb of 254
	localparam int unsigned PEND_W   = 7;   // at most seven bits stay pending
	localparam int unsigned ACC_W    = PEND_W + CODE_W;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned TOTAL_W  = 5;
	localparam int unsigned CNT_W    = 3;
	localparam int unsigned NBYTES_W = 2;

	localparam logic [VALUE_W-1:0] MAG_MAX   = 9'd254;
	localparam logic [FW_W-1:0]    FIELD_MAX = 4'd8;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ebp_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic emit;
	} ebp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [NBYTES_W-1:0] in_bytes;
		logic [NBYTES_W-1:0] bytes_left;
		logic                out_free;
	} ebp_stat_t;

	// index of the highest set bit of a nonzero byte
	function automatic logic [CNT_W-1:0] msb_index(input logic [BYTE_W-1:0] c);
		logic [CNT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[i]) begin
				idx = CNT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

>>> design/ebp_if.sv
// request channel interfaces for input items and output bytes
`default_nettype none
interface ebp_item_if;
	logic                valid;
	logic                ready;
	logic [1:0]          op;
	logic signed [8:0]   value;
	logic [3:0]          field_width;

	modport source (output valid, op, value, field_width, input ready);
	modport sink   (input valid, op, value, field_width, output ready);
endinterface

interface ebp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

>>> design/ebp_ctrl.sv
// controller state machine: takes items and sequences the byte emission
`default_nettype none
module ebp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire ebp_pkg::ebp_stat_t stat,
	output ebp_pkg::ebp_cmd_t      cmd
);
	import ebp_pkg::*;

	ebp_state_t state_q;
	ebp_state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && stat.in_bytes != '0) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.bytes_left == '0) begin
					state_next = ST_IDLE;
				end else if (stat.out_free && stat.bytes_left == NBYTES_W'(1)) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free && stat.bytes_left != '0;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/ebp_datapath.sv
// datapath: code builder, pending bit register, byte buffer and output register
`default_nettype none
module ebp_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [ebp_pkg::OP_W-1:0]   op,
	input  wire logic signed [ebp_pkg::VALUE_W-1:0] value,
	input  wire logic [ebp_pkg::FW_W-1:0]   field_width,
	input  wire ebp_pkg::ebp_cmd_t          cmd,
	output ebp_pkg::ebp_stat_t              stat,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [ebp_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_last
);
	import ebp_pkg::*;

	logic [PEND_W-1:0]   pend_bits_q;
	logic [CNT_W-1:0]    pend_cnt_q;
	logic [ACC_W-1:0]    acc_q;
	logic [TOTAL_W-1:0]  rem_q;
	logic [NBYTES_W-1:0] left_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_last_q;

	logic [VALUE_W-1:0]  mag_raw;
	logic [VALUE_W-1:0]  mag;
	logic [BYTE_W-1:0]   eg_c;
	logic [CNT_W-1:0]    eg_p;
	logic [FW_W-1:0]     fw_sat;
	logic [VALUE_W-1:0]  fw_mask;
	logic [CODE_W-1:0]   code;
	logic [LEN_W-1:0]    len;
	logic [ACC_W-1:0]    acc;
	logic [TOTAL_W-1:0]  total;
	logic [BYTE_W-1:0]   keep_mask;
	logic [ACC_W-1:0]    shifted;

	// magnitude with saturation and the exp-golomb value m+1
	always_comb begin
		mag_raw = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
		mag     = (mag_raw > MAG_MAX) ? MAG_MAX : mag_raw;
		eg_c    = mag[BYTE_W-1:0] + BYTE_W'(1);
		eg_p    = msb_index(eg_c);
		fw_sat  = (field_width > FIELD_MAX) ? FIELD_MAX : field_width;
		fw_mask = (VALUE_W'(1) << fw_sat) - VALUE_W'(1);
	end

	// code bits and length per operation
	always_comb begin
		code = '0;
		len  = '0;
		case (op)
			OP_SIGN: begin
				code = CODE_W'(value[VALUE_W-1]);
				len  = LEN_W'(1);
			end
			OP_FIELD: begin
				code = CODE_W'(value & fw_mask);
				len  = fw_sat;
			end
			OP_EXPG: begin
				code = CODE_W'(eg_c);
				len  = {eg_p, 1'b1};
			end
			default: begin
				code = '0;
				len  = '0;
			end
		endcase
	end

	// append code to the pending bits
	always_comb begin
		acc       = (ACC_W'(pend_bits_q) << len) | ACC_W'(code);
		total     = TOTAL_W'(pend_cnt_q) + TOTAL_W'(len);
		keep_mask = (BYTE_W'(1) << total[CNT_W-1:0]) - BYTE_W'(1);
		shifted   = acc_q >> rem_q;
	end

	// pending bits and byte buffer, loaded when an item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			left_q      <= '0;
		end else if (cmd.load) begin
			pend_bits_q <= acc[PEND_W-1:0] & keep_mask[PEND_W-1:0];
			pend_cnt_q  <= total[CNT_W-1:0];
			left_q      <= total[TOTAL_W-1:CNT_W];
		end else if (cmd.emit) begin
			left_q <= left_q - NBYTES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= acc;
			rem_q <= total - TOTAL_W'(BYTE_W);
		end else if (cmd.emit) begin
			rem_q <= rem_q - TOTAL_W'(BYTE_W);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= shifted[BYTE_W-1:0];
			out_last_q <= (left_q == NBYTES_W'(1));
		end
	end

	// status and outputs
	always_comb begin
		stat.in_bytes   = total[TOTAL_W-1:CNT_W];
		stat.bytes_left = left_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

>>> design/expgolomb_bit_packer_unit.sv
// top level of the exp-golomb bit packer: controller plus datapath
//
// channel  dir  payload                          handshake
// item     in   op[1:0] value[8:0] fw[3:0]       valid/ready
// result   out  out_byte[7:0] last               valid/ready
//
// an item completing no byte keeps the controller idle; otherwise the
// single output register moves one byte per cycle unless the result stalls.
// item.ready is high in idle, once every byte of the previous item has been
// moved into the output register; its last byte may still wait there.
// arst_n clears the pending bits, the controller and the output valid.
// a stalled result holds the byte in the output register and stops emission.
`default_nettype none
module expgolomb_bit_packer_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	ebp_item_if.sink  item,
	ebp_byte_if.source result
);
	import ebp_pkg::*;

	ebp_cmd_t  cmd;
	ebp_stat_t stat;
	logic      item_ready;

	// controller
	ebp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath
	ebp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (item.op),
		.value       (item.value),
		.field_width (item.field_width),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_byte    (result.out_byte),
		.out_last    (result.last)
	);

	assign item.ready = item_ready;

endmodule
`default_nettype wire

>>> design/ebp_checker.sv
// port-level checks for the exp-golomb bit packer, bound to the top level
`default_nettype none
module ebp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] res_byte,
	input wire logic       res_last
);

	// a stalled result keeps its valid
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_byte) && $stable(res_last))
		else $error("result payload changed while stalled");

	// the second byte of an item follows right after the first is taken
	a_second_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid)
		else $error("gap between bytes of one item");

	// no new request is taken while an item still has bytes to send
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !item_ready)
		else $error("item taken before previous item finished");

endmodule

bind expgolomb_bit_packer_unit ebp_checker u_ebp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_byte   (result.out_byte),
	.res_last   (result.last)
);
`default_nettype wire

>>> sim/expgolomb_bit_packer_unit_tb.sv
// self-checking testbench for the exp-golomb bit packer with random pacing on both channels
`timescale 1ns / 100ps
module expgolomb_bit_packer_unit_tb;
	import ebp_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 1600;
	localparam int REPORT_CAP   = 40;

	typedef struct {
		logic [1:0]        op;
		logic signed [8:0] value;
		logic [3:0]        field_width;
		bit                hold;      // sender waits until all bytes are out
	} code_req_t;

	typedef struct {
		logic [7:0] out_byte;
		logic       last;
	} packed_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	ebp_item_if item_ch ();
	ebp_byte_if byte_ch ();

	expgolomb_bit_packer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (byte_ch)
	);

	code_req_t    code_reqs[$];
	packed_byte_t expected_bytes[$];
	code_req_t    cur_req;

	// bitstream state of the predictor
	logic [6:0] pend_bits = '0;
	logic [2:0] pend_cnt  = '0;

	int mismatches     = 0;
	int reqs_accepted  = 0;
	int bytes_accepted = 0;
	int op_hits[4]     = '{0, 0, 0, 0};
	int holds_done     = 0;
	int idle_cycles    = 0;
	int gap_left       = 0;
	int stall_left     = 0;

	// every third stretch of 200 requests runs with no idling on either side
	wire quiet = ((reqs_accepted / 200) % 3) == 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait();
		if (quiet) begin
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_CAP) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// append the code of one request to the bitstream and queue finished bytes
	function automatic void pack_code(input code_req_t req);
		logic [14:0]  code;
		logic [8:0]   mag;
		logic [8:0]   sym;
		logic [21:0]  acc;
		int           len;
		int           prefix;
		int           total;
		int           n_bytes;
		packed_byte_t b;
		code = '0;
		len  = 0;
		case (req.op)
			OP_SIGN: begin
				code = 15'(req.value[8]);
				len  = 1;
			end
			OP_FIELD: begin
				len  = (req.field_width > FIELD_MAX) ? int'(FIELD_MAX) : int'(req.field_width);
				code = 15'(req.value[7:0]) & ((15'd1 << len) - 15'd1);
			end
			OP_EXPG: begin
				mag = req.value[8] ? (9'd0 - unsigned'(req.value)) : unsigned'(req.value);
				if (mag > MAG_MAX) begin
					mag = MAG_MAX;
				end
				sym    = mag + 9'd1;
				prefix = 0;
				while ((sym >> (prefix + 1)) != 0) begin
					prefix++;
				end
				code = 15'(sym);
				len  = 2 * prefix + 1;
			end
			default: begin
			end
		endcase
		acc     = (22'(pend_bits) << len) | 22'(code);
		total   = int'(pend_cnt) + len;
		n_bytes = (total / 8 > 2) ? 2 : total / 8;
		for (int i = 0; i < n_bytes; i++) begin
			total      -= 8;
			b.out_byte = 8'(acc >> total);
			b.last     = (i == n_bytes - 1);
			expected_bytes.push_back(b);
		end
		pend_cnt  = 3'(total);
		pend_bits = 7'(acc & ((22'd1 << pend_cnt) - 22'd1));
	endfunction

	function automatic void add_req(input logic [1:0] op, input int value, input int fw,
			input bit hold);
		code_req_t req;
		req.op          = op;
		req.value       = 9'(value);
		req.field_width = 4'(fw);
		req.hold        = hold;
		code_reqs.push_back(req);
	endfunction

	function automatic code_req_t random_req();
		code_req_t req;
		int        sel;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			req.op = OP_SIGN;
		end else if (sel < 60) begin
			req.op = OP_FIELD;
		end else if (sel < 95) begin
			req.op = OP_EXPG;
		end else begin
			req.op = OP_UNUSED;
		end
		// mix of full-range, small and saturating values
		case ($urandom_range(0, 3))
			0: req.value = 9'($urandom);
			1: req.value = 9'($urandom_range(0, 16) - 8);
			2: begin
				case ($urandom_range(0, 4))
					0: req.value = -9'sd256;
					1: req.value = -9'sd255;
					2: req.value = -9'sd254;
					3: req.value = 9'sd254;
					default: req.value = 9'sd255;
				endcase
			end
			default: req.value = 9'($urandom_range(0, 63) - 32);
		endcase
		if ($urandom_range(0, 9) < 8) begin
			req.field_width = 4'($urandom_range(1, 8));
		end else begin
			req.field_width = 4'($urandom_range(0, 15));
		end
		req.hold = ($urandom_range(0, 199) == 0);
		return req;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_reqs
		logic vld;
		int   gap;
		if (!arst_n) begin
			item_ch.valid       <= 1'b0;
			item_ch.op          <= '0;
			item_ch.value       <= '0;
			item_ch.field_width <= '0;
			gap_left            <= 0;
		end else begin
			vld = item_ch.valid;
			gap = gap_left;
			if (item_ch.valid && item_ch.ready) begin
				pack_code(cur_req);
				reqs_accepted++;
				op_hits[cur_req.op]++;
				vld = 1'b0;
				gap = draw_wait();
			end
			if (!vld) begin
				if (gap > 0) begin
					gap--;
				end else if (code_reqs.size() != 0 &&
						!(code_reqs[0].hold && expected_bytes.size() != 0)) begin
					cur_req = code_reqs.pop_front();
					if (cur_req.hold) begin
						holds_done++;
					end
					item_ch.op          <= cur_req.op;
					item_ch.value       <= cur_req.value;
					item_ch.field_width <= cur_req.field_width;
					vld = 1'b1;
				end
			end
			item_ch.valid <= vld;
			gap_left      <= gap;
		end
	end

	// byte monitor and checker
	always @(posedge clk or negedge arst_n) begin : check_bytes
		packed_byte_t want;
		int           s;
		if (!arst_n) begin
			byte_ch.ready <= 1'b0;
			stall_left    <= 0;
		end else begin
			s = stall_left;
			if (byte_ch.valid && byte_ch.ready) begin
				bytes_accepted++;
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %b",
						byte_ch.out_byte, byte_ch.last));
				end else begin
					want = expected_bytes.pop_front();
					if (byte_ch.out_byte !== want.out_byte) begin
						report_mismatch($sformatf("byte %0d: out_byte %02h, wanted %02h",
							bytes_accepted, byte_ch.out_byte, want.out_byte));
					end
					if (byte_ch.last !== want.last) begin
						report_mismatch($sformatf("byte %0d: last %b, wanted %b",
							bytes_accepted, byte_ch.last, want.last));
					end
				end
				s = draw_wait();
			end else if (s > 0) begin
				s--;
			end
			stall_left    <= s;
			byte_ch.ready <= (s == 0);
		end
	end

	// cycles with no request accepted on either channel
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		$display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int n_coded;
		code_req_t req;
		item_ch.valid       = 1'b0;
		item_ch.op          = '0;
		item_ch.value       = '0;
		item_ch.field_width = '0;
		byte_ch.ready       = 1'b0;
		arst_n              = 1'b0;

		// sign bits of both polarities and the extremes
		add_req(OP_SIGN, 0, 0, 0);
		add_req(OP_SIGN, -1, 15, 0);
		add_req(OP_SIGN, -256, 0, 0);
		add_req(OP_SIGN, 255, 5, 0);
		// fixed fields: zero width, full width, saturating widths
		add_req(OP_FIELD, 255, 0, 0);
		add_req(OP_FIELD, 9'h0a5, 8, 0);
		add_req(OP_FIELD, -1, 15, 0);
		add_req(OP_FIELD, 9'h15a, 9, 0);
		add_req(OP_FIELD, 1, 1, 0);
		add_req(OP_FIELD, -1, 4, 0);
		add_req(OP_FIELD, 0, 7, 0);
		// exp-golomb: shortest code, saturating magnitudes, both signs
		add_req(OP_EXPG, 0, 0, 0);
		add_req(OP_EXPG, 1, 0, 0);
		add_req(OP_EXPG, -1, 0, 0);
		add_req(OP_EXPG, 2, 0, 0);
		add_req(OP_EXPG, 254, 0, 0);
		add_req(OP_EXPG, 255, 0, 0);
		add_req(OP_EXPG, -255, 0, 0);
		add_req(OP_EXPG, -256, 15, 0);
		add_req(OP_EXPG, 127, 0, 0);
		add_req(OP_EXPG, -128, 0, 0);
		// unused op writes nothing
		add_req(OP_UNUSED, -1, 15, 0);
		add_req(OP_UNUSED, 0, 0, 0);
		// first random request waits until the block is drained
		n_coded = 0;
		req = random_req();
		req.hold = 1'b1;
		code_reqs.push_back(req);
		while (n_coded < RANDOM_ITEMS) begin
			req = random_req();
			code_reqs.push_back(req);
			if (req.op != OP_UNUSED) begin
				n_coded++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (code_reqs.size() != 0 || item_ch.valid) begin
			@(posedge clk);
		end
		while (expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (sign %0d, field %0d, exp-golomb %0d, unused %0d)",
			reqs_accepted, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
		$display("checked %0d bytes across %0d drain pauses, %0d mismatches",
			bytes_accepted, holds_done, mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
design/ebp_pkg.sv
design/ebp_if.sv
design/ebp_ctrl.sv
design/ebp_datapath.sv
design/expgolomb_bit_packer_unit.sv
design/ebp_checker.sv
sim/expgolomb_bit_packer_unit_tb.sv
